### hw/rtl/klrx_pkg.sv
// Package for the K-line response frame receiver: codes, limits and word types.
`default_nettype none
package klrx_pkg;

   localparam logic [7:0] MAX_DATA   = 8'd128;
   localparam logic [7:0] NEG_STATUS = 8'h7f;

   localparam logic [1:0] MODE_START   = 2'd0;
   localparam logic [1:0] MODE_BYTE    = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] FS_OK       = 2'd0;
   localparam logic [1:0] FS_ERROR    = 2'd1;
   localparam logic [1:0] FS_OVERFLOW = 2'd2;
   localparam logic [1:0] FS_BADSUM   = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ECHO,
      PH_LEN,
      PH_STATUS,
      PH_DATA,
      PH_CSUM,
      PH_DRAIN
   } phase_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [8:0] echo_count;
      logic [7:0] rx_byte;
   } request_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
      logic [7:0] byte_index;
      logic [1:0] frame_status;
      logic [7:0] data_count;
      logic [7:0] service_status;
   } result_type;

endpackage
`default_nettype wire

### hw/rtl/klrx_parser.sv
// Frame parser: phase state, counters and checksum, one word per cycle.
`default_nettype none
module klrx_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire klrx_pkg::request_type item,
   output logic                     res_valid,
   output klrx_pkg::result_type     res
);
   import klrx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [8:0] echo_left_ff, echo_left_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] status_byte_ff, status_byte_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] data_index_ff, data_index_in;

   logic [8:0] data_expected;
   logic [8:0] index_next;
   logic [8:0] echo_dec;

   // length 0 means no announced end
   assign data_expected = (frame_length_ff == 8'd0) ? 9'd256
                                                    : {1'b0, frame_length_ff} - 9'd1;
   assign index_next    = {1'b0, data_index_ff} + 9'd1;
   assign echo_dec      = echo_left_ff - 9'd1;

   always_comb begin
      phase_in        = phase_ff;
      echo_left_in    = echo_left_ff;
      frame_length_in = frame_length_ff;
      status_byte_in  = status_byte_ff;
      running_sum_in  = running_sum_ff;
      data_index_in   = data_index_ff;
      res_valid       = 1'b0;
      res             = '0;
      res.kind        = KIND_STATUS;
      res.data_count  = data_index_ff;

      if (item_valid) begin
         if (item.mode == MODE_START) begin
            echo_left_in    = item.echo_count;
            frame_length_in = 8'd0;
            status_byte_in  = 8'd0;
            running_sum_in  = 8'd0;
            data_index_in   = 8'd0;
            phase_in        = (item.echo_count != 9'd0) ? PH_ECHO : PH_LEN;
         end else if ((item.mode == MODE_BYTE || item.mode == MODE_TIMEOUT) &&
                      phase_ff != PH_IDLE) begin
            if (phase_ff == PH_DRAIN) begin
               // timeouts count as drained words too
               echo_left_in = echo_dec;
               if (echo_dec == 9'd0) begin
                  res_valid        = 1'b1;
                  res.frame_status = FS_ERROR;
                  phase_in         = PH_IDLE;
               end
            end else if (item.mode == MODE_TIMEOUT) begin
               res_valid        = 1'b1;
               res.frame_status = FS_ERROR;
               phase_in         = PH_IDLE;
            end else begin
               case (phase_ff)
                  PH_ECHO: begin
                     echo_left_in = echo_dec;
                     if (echo_dec == 9'd0) phase_in = PH_LEN;
                  end
                  PH_LEN: begin
                     frame_length_in = item.rx_byte;
                     running_sum_in  = item.rx_byte;
                     phase_in        = PH_STATUS;
                  end
                  PH_STATUS: begin
                     status_byte_in = item.rx_byte;
                     running_sum_in = running_sum_ff + item.rx_byte;
                     if (item.rx_byte == NEG_STATUS) begin
                        if (frame_length_ff == 8'd0) begin
                           res_valid        = 1'b1;
                           res.frame_status = FS_ERROR;
                           phase_in         = PH_IDLE;
                        end else begin
                           echo_left_in = {1'b0, frame_length_ff};
                           phase_in     = PH_DRAIN;
                        end
                     end else begin
                        phase_in = (data_expected == 9'd0) ? PH_CSUM : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     res_valid = 1'b1;
                     if (data_index_ff >= MAX_DATA) begin
                        res.frame_status = FS_OVERFLOW;
                        phase_in         = PH_IDLE;
                     end else begin
                        running_sum_in = running_sum_ff + item.rx_byte;
                        res.kind       = KIND_DATA;
                        res.data_byte  = item.rx_byte;
                        res.byte_index = data_index_ff;
                        res.data_count = index_next[7:0];
                        data_index_in  = index_next[7:0];
                        if (index_next == data_expected) phase_in = PH_CSUM;
                     end
                  end
                  PH_CSUM: begin
                     res_valid        = 1'b1;
                     res.frame_status = (item.rx_byte == running_sum_ff) ? FS_OK
                                                                         : FS_BADSUM;
                     phase_in         = PH_IDLE;
                  end
                  default: phase_in = PH_IDLE;
               endcase
            end
         end
      end
      res.service_status = status_byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_IDLE;
         echo_left_ff    <= 9'd0;
         frame_length_ff <= 8'd0;
         status_byte_ff  <= 8'd0;
         running_sum_ff  <= 8'd0;
         data_index_ff   <= 8'd0;
      end else begin
         phase_ff        <= phase_in;
         echo_left_ff    <= echo_left_in;
         frame_length_ff <= frame_length_in;
         status_byte_ff  <= status_byte_in;
         running_sum_ff  <= running_sum_in;
         data_index_ff   <= data_index_in;
      end
   end

endmodule
`default_nettype wire

### hw/rtl/klrx_out_buf.sv
// Two-entry result buffer that decouples the parser from rsp_stall.
`default_nettype none
module klrx_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire klrx_pkg::result_type push_word,
   output logic                      has_space,
   output logic                      out_valid,
   input  wire logic                 out_stall,
   output klrx_pkg::result_type      out_word
);
   import klrx_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type head_ff, head_in;
   result_type tail_ff, tail_in;
   logic       pop;

   assign has_space = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_word  = head_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = push_word;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_word;
            end else if (push) begin
               tail_in  = push_word;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule
`default_nettype wire

### hw/rtl/kline_response_frame_receiver_top.sv
// K-line response frame receiver: input register, parser and result buffer.
//
// Input channel req_*: one word per event - start (with echo_count), received
// byte (rx_byte) or byte timeout. Result channel rsp_*: a data word (kind 0)
// for each stored response byte, and one status word (kind 1) that closes
// each frame with ok, error, overflow or bad checksum.
// Throughput: one word per cycle while the result buffer has space; results
// pass combinationally from the input register into a two-entry result buffer.
// A word passes two register stages (input register, result buffer) before
// its result is at rsp_*. Words with no result still pass the input register.
// rsp_stall: the result buffer absorbs two words; after that the input
// register holds and req_stall rises until the receiver takes a word.
// Reset (synchronous, active high): phase returns to idle, all counters and
// the checksum clear, and both the input register and result buffer empty.
`default_nettype none
module kline_response_frame_receiver_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_mode,
   input  wire logic [8:0] req_echo_count,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_kind,
   output logic [7:0]      rsp_data_byte,
   output logic [7:0]      rsp_byte_index,
   output logic [1:0]      rsp_frame_status,
   output logic [7:0]      rsp_data_count,
   output logic [7:0]      rsp_service_status
);
   import klrx_pkg::*;

   logic        in_valid_ff, in_valid_in;
   request_type in_word_ff, in_word_in;
   logic        advance;
   logic        load;
   logic        res_valid;
   result_type  res;
   logic        has_space;
   result_type  out_word;

   assign advance   = in_valid_ff && has_space;
   assign req_stall = in_valid_ff && !has_space;
   assign load      = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (load) begin
         in_valid_in = 1'b1;
         in_word_in  = '{mode: req_mode, echo_count: req_echo_count,
                         rx_byte: req_rx_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_word_ff <= in_word_in;
   end

   klrx_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (in_word_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   klrx_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_word (res),
      .has_space (has_space),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_kind           = out_word.kind;
   assign rsp_data_byte      = out_word.data_byte;
   assign rsp_byte_index     = out_word.byte_index;
   assign rsp_frame_status   = out_word.frame_status;
   assign rsp_data_count     = out_word.data_count;
   assign rsp_service_status = out_word.service_status;

endmodule
`default_nettype wire

### hw/rtl/klrx_checker.sv
// Port-level checker for the frame receiver and its bind to the top level.
`default_nettype none
module klrx_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_kind,
   input wire logic [7:0] rsp_data_byte,
   input wire logic [7:0] rsp_byte_index,
   input wire logic [1:0] rsp_frame_status,
   input wire logic [7:0] rsp_data_count,
   input wire logic [7:0] rsp_service_status
);
   import klrx_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_data_byte) && $stable(rsp_byte_index) &&
         $stable(rsp_frame_status) && $stable(rsp_data_count) &&
         $stable(rsp_service_status))
      else $error("result word changed while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_data_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DATA |->
         rsp_frame_status == FS_OK && rsp_byte_index < MAX_DATA &&
         rsp_data_count == rsp_byte_index + 8'd1)
      else $error("data word fields inconsistent");

   a_status_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_STATUS |->
         rsp_data_byte == 8'd0 && rsp_byte_index == 8'd0 &&
         rsp_data_count <= MAX_DATA)
      else $error("status word fields inconsistent");

endmodule

bind kline_response_frame_receiver_top klrx_checker u_klrx_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_kind           (rsp_kind),
   .rsp_data_byte      (rsp_data_byte),
   .rsp_byte_index     (rsp_byte_index),
   .rsp_frame_status   (rsp_frame_status),
   .rsp_data_count     (rsp_data_count),
   .rsp_service_status (rsp_service_status)
);
`default_nettype wire

### tb/kline_response_frame_receiver_top_tb.sv
// Self-checking testbench for the K-line response frame receiver: directed table, random frames.
`timescale 1ns / 100ps
module kline_response_frame_receiver_top_tb;
   import klrx_pkg::*;

   localparam logic [1:0] MODE_IGNORED = 2'd3;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES  = 200;
   localparam int RANDOM_WORDS = 1500;

   typedef struct packed {
      logic [1:0] mode;
      logic [8:0] echo;
      logic [7:0] rx;
      logic       typed;   // want holds a hand-written result word
      result_type want;
   } vector_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_mode = MODE_START;
   logic [8:0] req_echo_count = '0;
   logic [7:0] req_rx_byte = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_index;
   logic [1:0] rsp_frame_status;
   logic [7:0] rsp_data_count;
   logic [7:0] rsp_service_status;

   // parser model state
   phase_type  parse_phase = PH_IDLE;
   logic [8:0] skip_left = '0;
   logic [7:0] len_q = '0;
   logic [7:0] svc_q = '0;
   logic [7:0] sum_q = '0;
   logic [7:0] idx_q = '0;

   result_type parsed_words[$];
   int         mismatches = 0;
   int         words_sent = 0;
   int         cycle_count = 0;
   int         noise_odds = 400;
   bit         steady = 1'b0;
   bit         hold_off_due = 1'b0;

   kline_response_frame_receiver_top uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_echo_count     (req_echo_count),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_data_count     (rsp_data_count),
      .rsp_service_status (rsp_service_status)
   );

   always #2 clock = ~clock;

   function automatic bit close_frame(input logic [1:0] st, output result_type r);
      r = '0;
      r.kind = KIND_STATUS;
      r.frame_status = st;
      r.data_count = idx_q;
      r.service_status = svc_q;
      parse_phase = PH_IDLE;
      return 1'b1;
   endfunction

   // advances the parser model by one word; returns 1 when a result word is due
   function automatic bit parse_event(input logic [1:0] mode, input logic [8:0] echo,
                                      input logic [7:0] b, output result_type r);
      r = '0;
      if (mode == MODE_START) begin
         skip_left = echo;
         len_q = '0;
         svc_q = '0;
         sum_q = '0;
         idx_q = '0;
         parse_phase = (echo != 9'd0) ? PH_ECHO : PH_LEN;
         return 1'b0;
      end
      if (mode == MODE_IGNORED || parse_phase == PH_IDLE)
         return 1'b0;
      // negative response: timeouts count toward the drain as well
      if (parse_phase == PH_DRAIN) begin
         skip_left = skip_left - 9'd1;
         if (skip_left == 9'd0)
            return close_frame(FS_ERROR, r);
         return 1'b0;
      end
      if (mode == MODE_TIMEOUT)
         return close_frame(FS_ERROR, r);
      case (parse_phase)
         PH_ECHO: begin
            skip_left = skip_left - 9'd1;
            if (skip_left == 9'd0)
               parse_phase = PH_LEN;
         end
         PH_LEN: begin
            len_q = b;
            sum_q = b;
            parse_phase = PH_STATUS;
         end
         PH_STATUS: begin
            svc_q = b;
            sum_q = sum_q + b;
            if (b == NEG_STATUS) begin
               if (len_q == 8'd0)
                  return close_frame(FS_ERROR, r);
               skip_left = {1'b0, len_q};
               parse_phase = PH_DRAIN;
            end else begin
               parse_phase = (len_q == 8'd1) ? PH_CSUM : PH_DATA;
            end
         end
         PH_DATA: begin
            if (idx_q >= MAX_DATA)
               return close_frame(FS_OVERFLOW, r);
            sum_q = sum_q + b;
            r.kind = KIND_DATA;
            r.data_byte = b;
            r.byte_index = idx_q;
            r.data_count = idx_q + 8'd1;
            r.service_status = svc_q;
            idx_q = idx_q + 8'd1;
            // length zero never ends here; the buffer limit closes it
            if (len_q != 8'd0 && idx_q == len_q - 8'd1)
               parse_phase = PH_CSUM;
            return 1'b1;
         end
         PH_CSUM: return close_frame((b == sum_q) ? FS_OK : FS_BADSUM, r);
         default: parse_phase = PH_IDLE;
      endcase
      return 1'b0;
   endfunction

   function automatic int draw_wait(input bit calm);
      if (calm)
         return 0;
      return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 2);
   endfunction

   function automatic logic [8:0] any_echo();
      return 9'($urandom_range(0, 257));
   endfunction

   function automatic result_type status_word(input logic [1:0] st, input logic [7:0] count,
                                              input logic [7:0] svc);
      result_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.frame_status = st;
      r.data_count = count;
      r.service_status = svc;
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic check_field(input string field, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   // valid stays high across back-to-back words; it only drops for a gap
   task automatic send_word(input logic [1:0] mode, input logic [8:0] echo,
                            input logic [7:0] rx, input bit typed = 1'b0,
                            input result_type want = '0);
      int         gap;
      bit         made;
      result_type out;
      gap = draw_wait(steady);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_echo_count <= echo;
      req_rx_byte <= rx;
      do @(posedge clock); while (req_stall);
      made = parse_event(mode, echo, rx, out);
      if (typed)
         parsed_words.push_back(want);
      else if (made)
         parsed_words.push_back(out);
   endtask

   task automatic frame_word(input logic [1:0] mode, input logic [8:0] echo,
                             input logic [7:0] rx);
      if ($urandom_range(1, noise_odds) == 1)
         send_word(2'($urandom), 9'($urandom_range(0, 3)), 8'($urandom));
      send_word(mode, echo, rx);
      words_sent++;
   endtask

   task automatic random_frame();
      int         pick;
      int         echo_n;
      int         len_n;
      int         data_n;
      logic [7:0] len_b;
      logic [7:0] status_b;
      logic [7:0] sum_b;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      echo_n = (pick == 0) ? $urandom_range(250, 257) : (pick < 50) ? 0 : $urandom_range(1, 6);
      frame_word(MODE_START, 9'(echo_n), 8'($urandom));
      repeat (echo_n)
         frame_word(($urandom_range(0, 39) == 0) ? MODE_TIMEOUT : MODE_BYTE, any_echo(),
                    8'($urandom));
      pick = $urandom_range(0, 59);
      len_n = (pick == 0) ? 0 : (pick == 1) ? 129 : (pick == 2) ? $urandom_range(130, 255) :
              (pick < 6) ? 1 : $urandom_range(2, 16);
      len_b = 8'(len_n);
      frame_word(MODE_BYTE, any_echo(), len_b);
      status_b = ($urandom_range(0, 5) == 0) ? NEG_STATUS : 8'($urandom);
      frame_word(MODE_BYTE, any_echo(), status_b);
      if (status_b == NEG_STATUS) begin
         repeat (len_n)
            frame_word(($urandom_range(0, 3) == 0) ? MODE_TIMEOUT : MODE_BYTE, any_echo(),
                       8'($urandom));
      end else begin
         data_n = (len_n == 0 || len_n > 129) ? int'(MAX_DATA) : len_n - 1;
         sum_b = len_b + status_b;
         repeat (data_n) begin
            b = 8'($urandom);
            sum_b = sum_b + b;
            frame_word(MODE_BYTE, any_echo(), b);
         end
         if (len_n == 0 || len_n > 129)
            frame_word(($urandom_range(0, 2) == 0) ? MODE_TIMEOUT : MODE_BYTE, any_echo(),
                       8'($urandom));
         else
            frame_word(MODE_BYTE, any_echo(),
                       ($urandom_range(0, 3) == 0) ? 8'($urandom) : sum_b);
      end
   endtask

   // result side
   initial begin
      int n;
      int taken;
      taken = 0;
      wait (reset == 1'b0);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         n = draw_wait((taken % 150) < 40);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = {rsp_kind, rsp_data_byte, rsp_byte_index, rsp_frame_status, rsp_data_count,
                rsp_service_status};
         if (parsed_words.size() == 0) begin
            flag_mismatch("result word with nothing pending");
         end else begin
            want = parsed_words.pop_front();
            check_field("kind", 8'(got.kind), 8'(want.kind));
            check_field("data_byte", got.data_byte, want.data_byte);
            check_field("byte_index", got.byte_index, want.byte_index);
            check_field("frame_status", 8'(got.frame_status), 8'(want.frame_status));
            check_field("data_count", got.data_count, want.data_count);
            check_field("service_status", got.service_status, want.service_status);
         end
      end
   end

   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d words pending", cycle_count, parsed_words.size());
      $display("kline_response_frame_receiver_top_tb failed");
      $finish;
   end

   initial begin
      vector_type plan[$];
      int         frame_no;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'hff, 1'b0, '0});     // idle: ignored
      plan.push_back(vector_type'{MODE_TIMEOUT, 9'd0, 8'h00, 1'b0, '0});  // idle: ignored
      plan.push_back(vector_type'{MODE_START, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_TIMEOUT, 9'd0, 8'h00, 1'b1,
                                  status_word(FS_ERROR, 8'd0, 8'h00)});
      plan.push_back(vector_type'{MODE_START, 9'd257, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_START, 9'd1, 8'h00, 1'b0, '0});    // restart while busy
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'haa, 1'b0, '0});     // echo
      plan.push_back(vector_type'{MODE_IGNORED, 9'd511, 8'hff, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h03, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'hff, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h01, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h03, 1'b1,
                                  status_word(FS_OK, 8'd2, 8'h00)});
      // length one: checksum right after status
      plan.push_back(vector_type'{MODE_START, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h01, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h10, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h00, 1'b1,
                                  status_word(FS_BADSUM, 8'd0, 8'h10)});
      // negative with length zero
      plan.push_back(vector_type'{MODE_START, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, NEG_STATUS, 1'b1,
                                  status_word(FS_ERROR, 8'd0, NEG_STATUS)});
      // negative drain of two, one of them a timeout
      plan.push_back(vector_type'{MODE_START, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h02, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, NEG_STATUS, 1'b0, '0});
      plan.push_back(vector_type'{MODE_TIMEOUT, 9'd0, 8'h00, 1'b0, '0});
      plan.push_back(vector_type'{MODE_BYTE, 9'd0, 8'h00, 1'b1,
                                  status_word(FS_ERROR, 8'd0, NEG_STATUS)});
      foreach (plan[i])
         send_word(plan[i].mode, plan[i].echo, plan[i].rx, plan[i].typed, plan[i].want);

      frame_no = 0;
      while (words_sent < RANDOM_WORDS) begin
         steady = (frame_no % 24) >= 8 && (frame_no % 24) < 12;
         if (frame_no % 24 == 8)
            hold_off_due = 1'b1;
         if (frame_no % 20 == 19) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (parsed_words.size() != 0);
         end
         noise_odds = ($urandom_range(0, 11) == 0) ? 8 : 400;
         random_frame();
         // stray words between frames
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
               send_word(2'($urandom_range(1, 3)), any_echo(), 8'($urandom));
         frame_no++;
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (parsed_words.size() != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("kline_response_frame_receiver_top_tb passed");
      else
         $display("kline_response_frame_receiver_top_tb failed");
      $finish;
   end

endmodule

### files.f
hw/rtl/klrx_pkg.sv
hw/rtl/klrx_parser.sv
hw/rtl/klrx_out_buf.sv
hw/rtl/kline_response_frame_receiver_top.sv
hw/rtl/klrx_checker.sv
tb/kline_response_frame_receiver_top_tb.sv
